FILE: rtl/tbcd_pkg.sv
package tbcd_pkg;

   // Decode modes held in the mode register. The unused code behaves as raw.
   localparam logic [1:0] MODE_RAW   = 2'd0;
   localparam logic [1:0] MODE_UTF8  = 2'd1;
   localparam logic [1:0] MODE_PAIR  = 2'd2;
   localparam logic [1:0] MODE_RESET = MODE_UTF8;

   // Result kinds.
   localparam logic [1:0] KIND_CHAR      = 2'd0;
   localparam logic [1:0] KIND_INVALID   = 2'd1;
   localparam logic [1:0] KIND_TRUNCATED = 2'd2;

   // UTF-8 lead byte patterns.
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_MATCH = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_MATCH = 8'hE0;
   localparam logic [7:0] LEAD2_BITS  = 8'h1F;
   localparam logic [7:0] LEAD3_BITS  = 8'h0F;

   typedef struct packed {
      logic [1:0] pending_count;
      logic [9:0] partial_value;
   } seq_state_type;

   typedef struct packed {
      logic        has_result;
      logic [15:0] code_point;
      logic [1:0]  kind;
      logic        string_done;
   } decode_result_type;

endpackage

FILE: rtl/tbcd_if.sv
interface tbcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_string;

   modport source (output valid, output byte_in, output end_of_string, input ready);
   modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

interface tbcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_point;
   logic [1:0]  kind;
   logic        string_done;

   modport source (output valid, output code_point, output kind, output string_done,
                   input ready);
   modport sink   (input valid, input code_point, input kind, input string_done,
                   output ready);
endinterface

FILE: rtl/tbcd_decode.sv
module tbcd_decode (
   input  logic [1:0]                  mode,
   input  tbcd_pkg::seq_state_type     cur_state,
   input  logic [7:0]                  byte_in,
   input  logic                        end_of_string,
   output tbcd_pkg::seq_state_type     nxt_state,
   output tbcd_pkg::decode_result_type result
);
   import tbcd_pkg::*;

   logic is_lead2;
   logic is_lead3;

   assign is_lead2 = (byte_in & LEAD2_MASK) == LEAD2_MATCH;
   assign is_lead3 = (byte_in & LEAD3_MASK) == LEAD3_MATCH;

   always_comb begin
      nxt_state          = cur_state;
      result.has_result  = 1'b1;
      result.code_point  = 16'd0;
      result.kind        = KIND_CHAR;
      result.string_done = end_of_string;
      case (mode)
         MODE_PAIR: begin
            if (cur_state.pending_count == 2'd0) begin
               if (end_of_string) begin
                  nxt_state          = '0;
                  result.kind        = KIND_TRUNCATED;
                  result.string_done = 1'b1;
               end else begin
                  // Hold the high byte until its partner arrives.
                  nxt_state.partial_value = {2'b00, byte_in};
                  nxt_state.pending_count = 2'd1;
                  result.has_result       = 1'b0;
               end
            end else begin
               result.code_point = {cur_state.partial_value[7:0], byte_in};
               nxt_state         = '0;
            end
         end
         MODE_UTF8: begin
            if (cur_state.pending_count == 2'd0) begin
               if (!byte_in[7]) begin
                  result.code_point = {8'd0, byte_in};
               end else if (is_lead2 || is_lead3) begin
                  if (end_of_string) begin
                     result.kind        = KIND_TRUNCATED;
                     result.string_done = 1'b1;
                  end else if (is_lead2) begin
                     nxt_state.partial_value = {2'b00, byte_in & LEAD2_BITS};
                     nxt_state.pending_count = 2'd1;
                     result.has_result       = 1'b0;
                  end else begin
                     nxt_state.partial_value = {2'b00, byte_in & LEAD3_BITS};
                     nxt_state.pending_count = 2'd2;
                     result.has_result       = 1'b0;
                  end
               end else begin
                  result.kind = KIND_INVALID;
               end
            end else if (cur_state.pending_count == 2'd1) begin
               result.code_point = {cur_state.partial_value, byte_in[5:0]};
               nxt_state         = '0;
            end else begin
               // Two continuation bytes still awaited (a count of three acts the same).
               if (end_of_string) begin
                  nxt_state          = '0;
                  result.kind        = KIND_TRUNCATED;
                  result.string_done = 1'b1;
               end else begin
                  nxt_state.partial_value = {cur_state.partial_value[3:0], byte_in[5:0]};
                  nxt_state.pending_count = 2'd1;
                  result.has_result       = 1'b0;
               end
            end
         end
         default: begin
            nxt_state         = '0;
            result.code_point = {8'd0, byte_in};
         end
      endcase
   end

endmodule

FILE: rtl/text_byte_to_code_point_decoder.sv
// Text byte to code point decoder.
//
// Encoded string bytes arrive one request at a time on the req_if channel,
// each flagged with end_of_string on the last byte of its string. Decoded
// results leave on the rsp_if channel as a code point, a kind (character,
// invalid byte skipped, or string truncated mid-sequence) and string_done.
// Both channels use a valid/ready handshake; a transfer happens on a rising
// clock edge with valid and ready both high.
//
// The decode mode (raw bytes, UTF-8 up to three bytes, or big-endian 16-bit
// pairs) is written through csr_write_enable/csr_write_data. The user must
// write it only while the block is idle; the block does not enforce this.
// Reset selects UTF-8 mode and drops any open sequence.
// A request is captured in an input register and decoded from there into
// the result register, which offers its result on rsp_if. One request is
// accepted every cycle while the input stage can move on. Requests that
// only open or extend a sequence produce no result. When the receiver stalls,
// the result register holds and the input stage keeps accepting until it
// holds an item that has a result to deliver; reset clears both stages.
module text_byte_to_code_point_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   tbcd_req_if.sink   req_if,
   tbcd_rsp_if.source rsp_if
);
   import tbcd_pkg::*;

   // Mode register.
   logic [1:0] mode_ff;
   logic [1:0] mode_in;

   // Input stage.
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_eos_ff;

   // Open sequence state.
   seq_state_type state_ff;
   seq_state_type state_nxt;
   seq_state_type state_in;

   // Result stage.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_code_point_ff;
   logic [1:0]  rsp_kind_ff;
   logic        rsp_done_ff;

   decode_result_type decoded;
   logic              s1_advance;
   logic              req_take;

   tbcd_decode u_decode (
      .mode          (mode_ff),
      .cur_state     (state_ff),
      .byte_in       (s1_byte_ff),
      .end_of_string (s1_eos_ff),
      .nxt_state     (state_nxt),
      .result        (decoded)
   );

   // The held item moves on when it yields nothing or the result register
   // is empty or being emptied this cycle.
   assign s1_advance = s1_valid_ff
                       && (!decoded.has_result || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign mode_in      = csr_write_enable ? csr_write_data : mode_ff;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign state_in     = s1_advance ? state_nxt : state_ff;
   assign rsp_valid_in = (s1_advance && decoded.has_result)
                         || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         s1_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_if.byte_in;
         s1_eos_ff  <= req_if.end_of_string;
      end
      if (s1_advance && decoded.has_result) begin
         rsp_code_point_ff <= decoded.code_point;
         rsp_kind_ff       <= decoded.kind;
         rsp_done_ff       <= decoded.string_done;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.code_point  = rsp_code_point_ff;
   assign rsp_if.kind        = rsp_kind_ff;
   assign rsp_if.string_done = rsp_done_ff;

endmodule

FILE: test/text_byte_to_code_point_decoder_tb.sv
module text_byte_to_code_point_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbcd_pkg::*;

   // The fourth mode code has no name in the package; it must decode as raw.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Cycles allowed after the last expected result before the block is
   // considered settled. The block holds at most two stages of work.
   localparam int DRAIN_CYCLES = 6;

   // The run is abandoned when this many cycles pass with no handshake on
   // either channel and no register write.
   localparam int WATCHDOG_LIMIT = 2000;

   // Share of cycles, in percent, in which either side idles at random.
   localparam int IDLE_PERCENT = 9;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;

   tbcd_req_if req_bus ();
   tbcd_rsp_if rsp_bus ();

   text_byte_to_code_point_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   // Shadow copy of the decoder: the mode register and the open sequence.
   logic [1:0]    mode_shadow;
   seq_state_type open_seq;

   // Code points still owed by the block, oldest first.
   decode_result_type pending_code_points[$];

   // Bytes of the string that is about to be sent.
   logic [7:0] string_bytes[$];

   int error_count;
   int quiet_cycles;

   // When set, neither side idles at random.
   bit steady_run;

   // The test bumps hold_starts to ask the receiver for a hold-off of
   // hold_length cycles; the receiver counts it down on its own.
   int hold_starts;
   int hold_length;
   int hold_seen;
   int hold_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (error_count < 30) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
      error_count++;
   endtask

   // Works out what the block must produce for one accepted byte, and moves
   // the shadow sequence state along the same way the block does.
   function automatic decode_result_type decode_next_byte(input logic [7:0] b,
                                                          input logic eos);
      decode_result_type r;
      r = '0;
      r.has_result = 1'b1;
      r.kind = KIND_CHAR;
      r.string_done = eos;
      case (mode_shadow)
         MODE_PAIR: begin
            if (open_seq.pending_count == 2'd0) begin
               if (eos) begin
                  // A lone high byte at the end of a string cannot form a pair.
                  r.kind = KIND_TRUNCATED;
               end else begin
                  open_seq.partial_value = {2'b00, b};
                  open_seq.pending_count = 2'd1;
                  r.has_result = 1'b0;
               end
            end else begin
               // Any open count means a high byte is held in the low 8 bits.
               r.code_point = {open_seq.partial_value[7:0], b};
               open_seq = '0;
            end
         end
         MODE_UTF8: begin
            if (open_seq.pending_count == 2'd0) begin
               if (!b[7]) begin
                  r.code_point = {8'h00, b};
               end else if ((b & LEAD2_MASK) == LEAD2_MATCH ||
                            (b & LEAD3_MASK) == LEAD3_MATCH) begin
                  if (eos) begin
                     r.kind = KIND_TRUNCATED;
                  end else begin
                     r.has_result = 1'b0;
                     if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
                        open_seq.partial_value = {2'b00, b & LEAD2_BITS};
                        open_seq.pending_count = 2'd1;
                     end else begin
                        open_seq.partial_value = {2'b00, b & LEAD3_BITS};
                        open_seq.pending_count = 2'd2;
                     end
                  end
               end else begin
                  // Stray continuation byte, a four-byte lead or a byte from F8 up.
                  r.kind = KIND_INVALID;
               end
            end else if (open_seq.pending_count == 2'd1) begin
               // Continuation top bits are not checked; the merge keeps 16 bits.
               r.code_point = {open_seq.partial_value, b[5:0]};
               open_seq = '0;
            end else begin
               // Two bytes still awaited; a count of three behaves the same.
               if (eos) begin
                  r.kind = KIND_TRUNCATED;
                  open_seq = '0;
               end else begin
                  open_seq.partial_value = {open_seq.partial_value[3:0], b[5:0]};
                  open_seq.pending_count = 2'd1;
                  r.has_result = 1'b0;
               end
            end
         end
         default: begin
            // Raw mode and the unused code: every byte is a character.
            r.code_point = {8'h00, b};
            open_seq = '0;
         end
      endcase
      return r;
   endfunction

   // Monitor: samples both channels and the register port at each rising
   // edge, checks delivered results against the oldest owed code point, and
   // predicts new ones from accepted requests. It also runs the watchdog.
   always @(posedge clock) begin : monitor
      decode_result_type predicted;
      decode_result_type owed;
      if (reset) begin
         mode_shadow = MODE_RESET;
         open_seq = '0;
         quiet_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_code_points.size() == 0) begin
               report_mismatch($sformatf("result %h kind %0d with nothing owed",
                                         rsp_bus.code_point, rsp_bus.kind));
            end else begin
               owed = pending_code_points.pop_front();
               if (rsp_bus.code_point !== owed.code_point) begin
                  report_mismatch($sformatf("code_point got %h want %h",
                                            rsp_bus.code_point, owed.code_point));
               end
               if (rsp_bus.kind !== owed.kind) begin
                  report_mismatch($sformatf("kind got %0d want %0d",
                                            rsp_bus.kind, owed.kind));
               end
               if (rsp_bus.string_done !== owed.string_done) begin
                  report_mismatch($sformatf("string_done got %b want %b",
                                            rsp_bus.string_done, owed.string_done));
               end
            end
         end
         if (csr_write_enable) begin
            mode_shadow = csr_write_data;
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = decode_next_byte(req_bus.byte_in, req_bus.end_of_string);
            if (predicted.has_result) begin
               pending_code_points.push_back(predicted);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             csr_write_enable) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("text_byte_to_code_point_decoder_tb: done, errors");
            $finish;
         end
      end
   end

   // Receiver: ready drops at random, or for a whole hold-off on request.
   always @(posedge clock) begin
      if (hold_seen != hold_starts) begin
         hold_seen = hold_starts;
         hold_left = hold_length;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Offers one byte, after a random gap now and then, and returns at the
   // edge where it was taken. Valid stays high between back-to-back requests.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      if (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.byte_in <= b;
      req_bus.end_of_string <= eos;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_string();
      foreach (string_bytes[i]) begin
         send_byte(string_bytes[i], i == string_bytes.size() - 1);
      end
   endtask

   // Stops sending and waits for every owed code point, then lets the block
   // finish any byte that only opened or extended a sequence. Sampling on
   // the falling edge keeps clear of the monitor's updates.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_code_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] continuation_byte();
      // Mostly proper continuations; sometimes any byte, since the top bits
      // are not checked.
      if ($urandom_range(9) == 0) begin
         return 8'($urandom);
      end
      return 8'h80 | 8'($urandom_range(63));
   endfunction

   // A string of well-formed UTF-8 characters with random payloads, with a
   // little noise mixed in and sometimes its final byte cut off.
   task automatic build_utf8_string();
      int chars;
      int pick;
      string_bytes.delete();
      chars = $urandom_range(1, 6);
      repeat (chars) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            string_bytes.push_back(8'($urandom_range(127)));
         end else if (pick < 70) begin
            string_bytes.push_back(LEAD2_MATCH | 8'($urandom_range(31)));
            string_bytes.push_back(continuation_byte());
         end else if (pick < 92) begin
            string_bytes.push_back(LEAD3_MATCH | 8'($urandom_range(15)));
            string_bytes.push_back(continuation_byte());
            string_bytes.push_back(continuation_byte());
         end else begin
            string_bytes.push_back(8'($urandom));
         end
      end
      if (string_bytes.size() > 1 && $urandom_range(99) < 10) begin
         void'(string_bytes.pop_back());
      end
   endtask

   task automatic build_random_string(input int max_len);
      string_bytes.delete();
      repeat ($urandom_range(1, max_len)) string_bytes.push_back(8'($urandom));
   endtask

   // UTF-8 basics: one-, two- and three-byte characters, stray bytes, a
   // four-byte lead, strings cut off at and after the lead, and an encoded
   // surrogate that passes through unchecked.
   task automatic test_utf8_cases();
      write_mode(MODE_UTF8);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hC3, 1'b1);
      send_byte(8'hE4, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'hED, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   // Byte pairs at both extremes, and a string that ends on a high byte.
   task automatic test_pair_cases();
      write_mode(MODE_PAIR);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h12, 1'b1);
   endtask

   // Raw mode passes every byte through, and so does the unused mode code.
   task automatic test_raw_cases();
      write_mode(MODE_RAW);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      write_mode(MODE_UNUSED);
      send_byte(8'h80, 1'b1);
   endtask

   // A mode write leaves an open sequence in place: a UTF-8 lead becomes a
   // held high byte in pair mode, a held high byte becomes UTF-8 payload, and
   // raw mode drops whatever is open.
   task automatic test_mode_change();
      write_mode(MODE_UTF8);
      send_byte(8'hE2, 1'b0);
      write_mode(MODE_PAIR);
      send_byte(8'h41, 1'b1);
      send_byte(8'h9C, 1'b0);
      write_mode(MODE_UTF8);
      send_byte(8'h85, 1'b0);
      send_byte(8'hC5, 1'b0);
      write_mode(MODE_RAW);
      send_byte(8'h7A, 1'b1);
   endtask

   // The receiver holds off long enough for the block to fill and stall its
   // input while requests keep coming; then the sender waits for the drain.
   task automatic test_backpressure();
      write_mode(MODE_UTF8);
      steady_run = 1'b1;
      hold_length = 60;
      hold_starts++;
      repeat (40) send_byte(8'($urandom_range(127)), 1'($urandom_range(1)));
      steady_run = 1'b0;
      wait_idle();
   endtask

   // Random strings in phases, each phase in one mode. The second UTF-8
   // phase runs with no idling on either side.
   task automatic test_random_strings();
      logic [1:0] phase_mode [7] = '{MODE_UTF8, MODE_PAIR, MODE_RAW, MODE_UTF8,
                                     MODE_UNUSED, MODE_PAIR, MODE_UTF8};
      int phase_items [7] = '{180, 110, 70, 180, 50, 110, 160};
      int sent;
      for (int p = 0; p < 7; p++) begin
         write_mode(phase_mode[p]);
         steady_run = (p == 3);
         sent = 0;
         while (sent < phase_items[p]) begin
            if (phase_mode[p] == MODE_UTF8 && $urandom_range(99) < 85) begin
               build_utf8_string();
            end else begin
               build_random_string(9);
            end
            send_string();
            sent += string_bytes.size();
         end
         steady_run = 1'b0;
      end
   endtask

   initial begin
      // Every input of the block is known from time zero.
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = MODE_RESET;
      req_bus.valid = 1'b0;
      req_bus.byte_in = 8'h00;
      req_bus.end_of_string = 1'b0;
      rsp_bus.ready = 1'b0;
      error_count = 0;
      steady_run = 1'b0;
      hold_starts = 0;
      hold_length = 0;
      hold_seen = 0;
      hold_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_utf8_cases();
      test_pair_cases();
      test_raw_cases();
      test_mode_change();
      test_backpressure();
      test_random_strings();

      wait_idle();
      if (pending_code_points.size() != 0) begin
         report_mismatch($sformatf("%0d code points never delivered",
                                   pending_code_points.size()));
      end
      if (error_count == 0) begin
         $display("text_byte_to_code_point_decoder_tb: done, clean");
      end else begin
         $display("text_byte_to_code_point_decoder_tb: done, errors");
      end
      $finish;
   end

endmodule
